>>> src/ptds_pkg.sv
// ----------------------------------------------------------------------------
// ptds_pkg: shared types and constants of the periodic task due scheduler
// Operation codes, result kinds, field widths and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptds_pkg;

  // Widths of the item fields.
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int MAX_SLOTS = 16;

  // Operation carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_SET_ENABLE = 2'd2,
    OP_RUN        = 2'd3
  } op_t;

  // Kind of a result item.
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_DUE  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  // Status of a result item.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Write strobes into the slot memory.
  typedef struct packed {
    logic per_en;
    logic lr_en;
  } mem_wr_t;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_CMD  = 10'b00_0000_0010,
    S_RESP = 10'b00_0000_0100,
    S_FIND = 10'b00_0000_1000,
    S_SCAN = 10'b00_0001_0000,
    S_CHK  = 10'b00_0010_0000,
    S_ADV  = 10'b00_0100_0000,
    S_SNAP = 10'b00_1000_0000,
    S_PUSH = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

>>> src/ptds_alu.sv
// ----------------------------------------------------------------------------
// ptds_alu: shared add/subtract and compare unit
// Computes a + b or a - b modulo 2^32 and compares the result against c.
// ----------------------------------------------------------------------------
`default_nettype none

module ptds_alu (
  input  wire logic [ptds_pkg::WORD_W-1:0] a,
  input  wire logic [ptds_pkg::WORD_W-1:0] b,
  input  wire logic [ptds_pkg::WORD_W-1:0] c,
  input  wire logic                        sub,
  output logic      [ptds_pkg::WORD_W-1:0] res,
  output logic                             ge
);

  // One adder serves both directions; the compare follows it.
  assign res = sub ? (a - b) : (a + b);
  assign ge  = (res >= c);

endmodule

`default_nettype wire

>>> src/ptds_slot_mem.sv
// ----------------------------------------------------------------------------
// ptds_slot_mem: interval and last-run storage of the task slots
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptds_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [ptds_pkg::WORD_W-1:0] rd_per,
  output logic      [ptds_pkg::WORD_W-1:0] rd_lr,
  input  wire ptds_pkg::mem_wr_t           wr,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ptds_pkg::WORD_W-1:0] wr_per,
  input  wire logic [ptds_pkg::WORD_W-1:0] wr_lr
);

  logic [ptds_pkg::WORD_W-1:0] per_mem [DEPTH];
  logic [ptds_pkg::WORD_W-1:0] lr_mem  [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.per_en) begin
      per_mem[wr_addr] <= wr_per;
    end
    if (wr.lr_en) begin
      lr_mem[wr_addr] <= wr_lr;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_per <= per_mem[rd_addr];
      rd_lr  <= lr_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/periodic_task_due_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_due_scheduler_core: table of periodic task slots
// Registers, frees and enables task slots and reports the slots that are due
// at a given tick, walking the table one slot at a time.
// ----------------------------------------------------------------------------
// Unregister and set enable pass a command state, then the acknowledge;
// register rejects a zero interval at once, else seeks the lowest free slot.
// Run skips unused or disabled slots and checks each live slot; a due slot
// takes three passes through the shared adder and a memory read, then the run
// finishes. The sequencer waits on a stalled output and takes one item at
// a time. Reset (synchronous, rst_n low) empties the table and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_due_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // now_tick[31:0], period[63:32], slot[67:64],
                                       // enable_flag[68], zero[71:69]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // status[0], slot_out[4:1], zero[7:5]
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast
);

  localparam int WORD_W = ptds_pkg::WORD_W;
  localparam int SLOT_W = ptds_pkg::SLOT_W;
  localparam int ACTIVE = (SLOTS > ptds_pkg::MAX_SLOTS) ? ptds_pkg::MAX_SLOTS : SLOTS;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(ACTIVE - 1);
  localparam logic [SLOT_W:0]   ACTIVE_EXT = (SLOT_W + 1)'(ACTIVE);

  // Control state.
  ptds_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ACTIVE-1:0] used_r, used_nxt;
  logic [ACTIVE-1:0] enabled_r, enabled_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  ptds_pkg::op_t      op_r, op_nxt;
  logic [WORD_W-1:0]  now_r, now_nxt;
  logic [WORD_W-1:0]  per_r, per_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               en_r, en_nxt;
  logic [WORD_W-1:0]  lr2_r, lr2_nxt;
  logic [IDX_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic               resp_status_r, resp_status_nxt;
  logic [SLOT_W-1:0]  resp_slot_r, resp_slot_nxt;
  ptds_pkg::kind_t    out_kind_r, out_kind_nxt;
  logic               out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_last_r, out_last_nxt;

  // Shared unit and memory hookup.
  logic [WORD_W-1:0]  alu_a, alu_b, alu_res;
  logic               alu_sub, alu_ge;
  logic               rd_en;
  logic [WORD_W-1:0]  rd_per, rd_lr;
  ptds_pkg::mem_wr_t  mem_wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_per, wr_lr;

  logic               out_free;
  logic               slot_ok;
  logic [IDX_W-1:0]   slot_idx;

  ptds_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (rd_per),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  ptds_slot_mem #(
    .DEPTH (ACTIVE),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_per  (rd_per),
    .rd_lr   (rd_lr),
    .wr      (mem_wr),
    .wr_addr (wr_addr),
    .wr_per  (wr_per),
    .wr_lr   (wr_lr)
  );

  // The output register can take a new item when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ptds_pkg::S_IDLE);

  // Slot index check for unregister and set enable.
  assign slot_idx = slot_r[IDX_W-1:0];
  assign slot_ok  = ({1'b0, slot_r} < ACTIVE_EXT) && used_r[slot_idx];

  // Shared unit operand selection: elapsed time, advance, then re-check.
  always_comb begin
    alu_a   = now_r;
    alu_b   = rd_lr;
    alu_sub = 1'b1;
    case (state_r)
      ptds_pkg::S_ADV: begin
        alu_a   = rd_lr;
        alu_b   = rd_per;
        alu_sub = 1'b0;
      end
      ptds_pkg::S_SNAP: begin
        alu_a   = now_r;
        alu_b   = lr2_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = now_r;
        alu_b   = rd_lr;
        alu_sub = 1'b1;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    used_nxt        = used_r;
    enabled_nxt     = enabled_r;
    pend_v_nxt      = pend_v_r;
    pend_slot_nxt   = pend_slot_r;
    op_nxt          = op_r;
    now_nxt         = now_r;
    per_nxt         = per_r;
    slot_nxt        = slot_r;
    en_nxt          = en_r;
    lr2_nxt         = lr2_r;
    resp_status_nxt = resp_status_r;
    resp_slot_nxt   = resp_slot_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    rd_en           = 1'b0;
    mem_wr          = '0;
    wr_addr         = idx_r;
    wr_per          = per_r;
    wr_lr           = now_r;

    case (state_r)
      ptds_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = ptds_pkg::op_t'(in_tuser);
          now_nxt  = in_tdata[31:0];
          per_nxt  = in_tdata[63:32];
          slot_nxt = in_tdata[67:64];
          en_nxt   = in_tdata[68];
          idx_nxt  = '0;
          pend_v_nxt = 1'b0;
          case (ptds_pkg::op_t'(in_tuser))
            ptds_pkg::OP_REGISTER: begin
              if (in_tdata[63:32] == '0) begin
                resp_status_nxt = ptds_pkg::STATUS_REJECTED;
                resp_slot_nxt   = '0;
                state_nxt       = ptds_pkg::S_RESP;
              end else begin
                state_nxt = ptds_pkg::S_FIND;
              end
            end
            ptds_pkg::OP_RUN: state_nxt = ptds_pkg::S_SCAN;
            default:          state_nxt = ptds_pkg::S_CMD;
          endcase
        end
      end

      // Unregister or set enable on a single slot.
      ptds_pkg::S_CMD: begin
        resp_slot_nxt = '0;
        wr_addr       = slot_idx;
        if (!slot_ok) begin
          resp_status_nxt = ptds_pkg::STATUS_REJECTED;
        end else begin
          resp_status_nxt = ptds_pkg::STATUS_OK;
          if (op_r == ptds_pkg::OP_UNREGISTER) begin
            used_nxt[slot_idx]    = 1'b0;
            enabled_nxt[slot_idx] = 1'b0;
            mem_wr.per_en         = 1'b1;
            mem_wr.lr_en          = 1'b1;
            wr_per                = '0;
            wr_lr                 = '0;
          end else begin
            enabled_nxt[slot_idx] = en_r;
          end
        end
        state_nxt = ptds_pkg::S_RESP;
      end

      // Single acknowledge item.
      ptds_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ptds_pkg::KIND_ACK;
          out_status_nxt = resp_status_r;
          out_slot_nxt   = resp_slot_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ptds_pkg::S_IDLE;
        end
      end

      // Search for the lowest free slot.
      ptds_pkg::S_FIND: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r]    = 1'b1;
          enabled_nxt[idx_r] = 1'b1;
          mem_wr.per_en      = 1'b1;
          mem_wr.lr_en       = 1'b1;
          resp_status_nxt    = ptds_pkg::STATUS_OK;
          resp_slot_nxt      = SLOT_W'(idx_r);
          state_nxt          = ptds_pkg::S_RESP;
        end else if (idx_r == IDX_LAST) begin
          resp_status_nxt = ptds_pkg::STATUS_REJECTED;
          resp_slot_nxt   = '0;
          state_nxt       = ptds_pkg::S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Visit a slot; live slots get their interval and last run read.
      ptds_pkg::S_SCAN: begin
        if (used_r[idx_r] && enabled_r[idx_r]) begin
          rd_en     = 1'b1;
          state_nxt = ptds_pkg::S_CHK;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = ptds_pkg::S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Elapsed time against the interval.
      ptds_pkg::S_CHK: begin
        if (alu_ge) begin
          state_nxt = ptds_pkg::S_ADV;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = ptds_pkg::S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ptds_pkg::S_SCAN;
        end
      end

      // Advance last run by one interval.
      ptds_pkg::S_ADV: begin
        lr2_nxt   = alu_res;
        state_nxt = ptds_pkg::S_SNAP;
      end

      // Snap to the current tick if still a full interval behind.
      ptds_pkg::S_SNAP: begin
        mem_wr.lr_en = 1'b1;
        wr_lr        = alu_ge ? now_r : lr2_r;
        state_nxt    = ptds_pkg::S_PUSH;
      end

      // Hold the due slot; the one before it is sent as not last.
      ptds_pkg::S_PUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ptds_pkg::KIND_DUE;
            out_status_nxt = ptds_pkg::STATUS_OK;
            out_slot_nxt   = SLOT_W'(pend_slot_r);
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx_r;
          if (idx_r == IDX_LAST) begin
            state_nxt = ptds_pkg::S_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ptds_pkg::S_SCAN;
          end
        end
      end

      // Final item of a run.
      ptds_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ptds_pkg::STATUS_OK;
          out_last_nxt   = 1'b1;
          if (pend_v_r) begin
            out_kind_nxt = ptds_pkg::KIND_DUE;
            out_slot_nxt = SLOT_W'(pend_slot_r);
          end else begin
            out_kind_nxt = ptds_pkg::KIND_NONE;
            out_slot_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ptds_pkg::S_IDLE;
        end
      end

      default: state_nxt = ptds_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptds_pkg::S_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      enabled_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      enabled_r   <= enabled_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    now_r         <= now_nxt;
    per_r         <= per_nxt;
    slot_r        <= slot_nxt;
    en_r          <= en_nxt;
    lr2_r         <= lr2_nxt;
    pend_slot_r   <= pend_slot_nxt;
    resp_status_r <= resp_status_nxt;
    resp_slot_r   <= resp_slot_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Result channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_slot_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
